// ===== sv/ptnc_pkg.sv =====
// Package for the palette table with nearest-color search.
// Holds palette geometry, action and status codes, and the entry layout.
// No dependencies.
`default_nettype none

package ptnc_pkg;

   localparam int unsigned PALETTE_DEPTH = 256;
   localparam int unsigned ADDR_W        = $clog2(PALETTE_DEPTH);
   localparam int unsigned CNT_W         = $clog2(PALETTE_DEPTH + 1);
   localparam int unsigned IDX_W         = 16;
   localparam int unsigned REG_W         = 9;
   localparam int unsigned DIST_W        = 18;

   localparam logic [DIST_W-1:0] DIST_START = 18'h30000;

   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_READ    = 2'd1;
   localparam logic [1:0] ACT_NEAREST = 2'd2;
   localparam logic [1:0] ACT_RESOLVE = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [7:0] flags;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } entry_type;

endpackage

`default_nettype wire

// ===== sv/palette_table_nearest_color.sv =====
// Palette table: entry write/read, nearest-color search and color resolve.
// Single module with the palette memory and a small sequencer.
// Depends on ptnc_pkg.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | action, index, rgb, flags, direct, last
//  rsp     | out       | rsp_valid/ready    | status, rgb, flags, nearest index, run end
//  csr     | in        | csr_valid/ready    | entry_count
//
// One item at a time. Nearest search reads one palette entry per cycle through the
// single memory read port and the shared distance unit; an exact match stops it early.
// Synchronous reset clears the valid bits, so every entry reads as zero until written.
// A finished result waits in the output register; the next item is taken meanwhile.
`default_nettype none

module palette_table_nearest_color (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_index,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   input  wire logic [7:0]  req_entry_flags,
   input  wire logic        req_direct_rgb,
   input  wire logic        req_last_in_run,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic [7:0]       rsp_out_flags,
   output logic [7:0]       rsp_nearest_index,
   output logic             rsp_run_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [8:0]  csr_entry_count
);

   localparam int unsigned DEPTH  = ptnc_pkg::PALETTE_DEPTH;
   localparam int unsigned ADDR_W = ptnc_pkg::ADDR_W;
   localparam int unsigned CNT_W  = ptnc_pkg::CNT_W;
   localparam int unsigned IDX_W  = ptnc_pkg::IDX_W;
   localparam int unsigned DIST_W = ptnc_pkg::DIST_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_SEARCH = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   // palette memory and per-entry valid bits
   ptnc_pkg::entry_type mem [DEPTH];
   logic [DEPTH-1:0]    mem_vld_ff;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff;

   // latched item
   logic [1:0]        act_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [7:0]        red_ff, green_ff, blue_ff, flags_ff;
   logic              direct_ff, last_ff;

   // result under construction
   logic [1:0]        res_stat_ff, res_stat_in;
   logic [7:0]        res_red_ff, res_red_in;
   logic [7:0]        res_green_ff, res_green_in;
   logic [7:0]        res_blue_ff, res_blue_in;
   logic [7:0]        res_flags_ff, res_flags_in;

   // search pipeline
   logic [CNT_W-1:0]  iss_ptr_ff, iss_ptr_in;
   logic              p1_vld_ff, p1_vld_in;
   logic [ADDR_W-1:0] p1_idx_ff;
   logic              p2_vld_ff, p2_vld_in;
   logic [ADDR_W-1:0] p2_idx_ff;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [ADDR_W-1:0] near_ff, near_in;

   // memory read port
   ptnc_pkg::entry_type rd_word_ff;
   logic                rd_vld_ff;
   logic [ADDR_W-1:0]   rd_addr;
   ptnc_pkg::entry_type rd_entry;
   logic                mem_we;
   ptnc_pkg::entry_type wr_word;

   // output register
   logic              rsp_valid_ff;
   logic [1:0]        out_stat_ff;
   logic [7:0]        out_red_ff, out_green_ff, out_blue_ff, out_flags_ff, out_near_ff;
   logic              out_last_ff;

   logic              accept, in_range, issuing, search_done, out_load;
   logic [7:0]        dr, dg, db;
   logic [15:0]       sq_r, sq_g, sq_b;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign csr_ready = !reset;
   assign in_range  = idx_ff < IDX_W'(cnt_ff);
   assign issuing   = (state_ff == S_SEARCH) && (iss_ptr_ff < cnt_ff);
   assign rd_entry  = rd_vld_ff ? rd_word_ff : '0;
   assign out_load  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign mem_we  = (state_ff == S_START) && (act_ff == ptnc_pkg::ACT_WRITE) && in_range;
   assign wr_word = '{flags: flags_ff, blue: blue_ff, green: green_ff, red: red_ff};
   assign rd_addr = issuing ? iss_ptr_ff[ADDR_W-1:0]
                            : (in_range ? idx_ff[ADDR_W-1:0] : '0);

   // shared distance unit
   always_comb begin
      dr      = (rd_entry.red > red_ff) ? rd_entry.red - red_ff : red_ff - rd_entry.red;
      dg      = (rd_entry.green > green_ff) ? rd_entry.green - green_ff
                                            : green_ff - rd_entry.green;
      db      = (rd_entry.blue > blue_ff) ? rd_entry.blue - blue_ff : blue_ff - rd_entry.blue;
      sq_r    = 16'(dr) * 16'(dr);
      sq_g    = 16'(dg) * 16'(dg);
      sq_b    = 16'(db) * 16'(db);
      dist_in = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
   end

   always_comb begin
      state_in     = state_ff;
      res_stat_in  = res_stat_ff;
      res_red_in   = res_red_ff;
      res_green_in = res_green_ff;
      res_blue_in  = res_blue_ff;
      res_flags_in = res_flags_ff;
      iss_ptr_in   = iss_ptr_ff;
      best_in      = best_ff;
      near_in      = near_ff;
      search_done  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_START;
            end
         end
         S_START: begin
            res_stat_in  = ptnc_pkg::STAT_OK;
            res_red_in   = '0;
            res_green_in = '0;
            res_blue_in  = '0;
            res_flags_in = '0;
            iss_ptr_in   = '0;
            best_in      = ptnc_pkg::DIST_START;
            near_in      = '0;
            state_in     = S_FINISH;
            case (act_ff)
               ptnc_pkg::ACT_WRITE, ptnc_pkg::ACT_READ: begin
                  if (!in_range) begin
                     res_stat_in = ptnc_pkg::STAT_RANGE;
                  end else if (act_ff == ptnc_pkg::ACT_READ) begin
                     state_in = S_RDWAIT;
                  end
               end
               ptnc_pkg::ACT_NEAREST: begin
                  if (cnt_ff == '0) begin
                     res_stat_in = ptnc_pkg::STAT_EMPTY;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
               default: begin
                  if (direct_ff) begin
                     res_red_in   = red_ff;
                     res_green_in = green_ff;
                     res_blue_in  = blue_ff;
                  end else begin
                     state_in = S_RDWAIT;
                  end
               end
            endcase
         end
         S_RDWAIT: begin
            res_red_in   = rd_entry.red;
            res_green_in = rd_entry.green;
            res_blue_in  = rd_entry.blue;
            res_flags_in = (act_ff == ptnc_pkg::ACT_READ) ? rd_entry.flags : '0;
            state_in     = S_FINISH;
         end
         S_SEARCH: begin
            if (issuing) begin
               iss_ptr_in = iss_ptr_ff + CNT_W'(1);
            end
            if (p2_vld_ff && (dist_ff < best_ff)) begin
               best_in = dist_ff;
               near_in = p2_idx_ff;
            end
            if ((p2_vld_ff && (dist_ff == '0)) || (!issuing && !p1_vld_ff)) begin
               search_done = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign p1_vld_in = issuing && !search_done;
   assign p2_vld_in = p1_vld_ff && (state_ff == S_SEARCH) && !search_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         mem_vld_ff   <= '0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         p1_vld_ff <= p1_vld_in;
         p2_vld_ff <= p2_vld_in;
         if (csr_valid && csr_ready) begin
            cnt_ff <= (IDX_W'(csr_entry_count) > IDX_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                                : CNT_W'(csr_entry_count);
         end
         if (mem_we) begin
            mem_vld_ff[idx_ff[ADDR_W-1:0]] <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff[ADDR_W-1:0]] <= wr_word;
      end
      rd_word_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      rd_vld_ff <= mem_vld_ff[rd_addr];
      if (accept) begin
         act_ff    <= req_action;
         idx_ff    <= req_index;
         red_ff    <= req_red;
         green_ff  <= req_green;
         blue_ff   <= req_blue;
         flags_ff  <= req_entry_flags;
         direct_ff <= req_direct_rgb;
         last_ff   <= req_last_in_run;
      end
      res_stat_ff  <= res_stat_in;
      res_red_ff   <= res_red_in;
      res_green_ff <= res_green_in;
      res_blue_ff  <= res_blue_in;
      res_flags_ff <= res_flags_in;
      iss_ptr_ff   <= iss_ptr_in;
      best_ff      <= best_in;
      near_ff      <= near_in;
      p1_idx_ff    <= iss_ptr_ff[ADDR_W-1:0];
      p2_idx_ff    <= p1_idx_ff;
      dist_ff      <= dist_in;
      if (out_load) begin
         out_stat_ff  <= res_stat_ff;
         out_red_ff   <= res_red_ff;
         out_green_ff <= res_green_ff;
         out_blue_ff  <= res_blue_ff;
         out_flags_ff <= res_flags_ff;
         out_near_ff  <= 8'(near_ff);
         out_last_ff  <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_stat_ff;
   assign rsp_out_red       = out_red_ff;
   assign rsp_out_green     = out_green_ff;
   assign rsp_out_blue      = out_blue_ff;
   assign rsp_out_flags     = out_flags_ff;
   assign rsp_nearest_index = out_near_ff;
   assign rsp_run_end       = out_last_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_START)
      else $error("accepted item did not start the sequencer");

   a_search_idx_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && p2_vld_ff) |-> CNT_W'(p2_idx_ff) < cnt_ff)
      else $error("search compared an entry beyond the live count");

   a_best_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> best_ff <= ptnc_pkg::DIST_START)
      else $error("best distance above start value");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result presented outside finish");

endmodule

`default_nettype wire

// ===== test/palette_table_nearest_color_tb.sv =====
// Testbench for palette_table_nearest_color: a mirrored palette predicts every response.
// Directed corner items, then randomized phases with random idling on both channels.
// Depends on ptnc_pkg and palette_table_nearest_color.
`timescale 1ns / 100ps

typedef struct packed {
   logic [1:0]  action;
   logic [15:0] index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  entry_flags;
   logic        direct_rgb;
   logic        last_in_run;
} palette_req_type;

typedef struct packed {
   logic [1:0] status;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] flags;
   logic [7:0] nearest_index;
   logic       run_end;
} palette_rsp_type;

class palette_mirror;
   ptnc_pkg::entry_type        mirror [ptnc_pkg::PALETTE_DEPTH];
   logic [ptnc_pkg::REG_W-1:0] entry_count;
   palette_rsp_type            expected_rsp [$];
   int unsigned                errors;

   function new();
      foreach (mirror[i]) mirror[i] = '0;
      entry_count = '0;
      errors      = 0;
   endfunction

   function void set_entry_count(logic [ptnc_pkg::REG_W-1:0] value);
      entry_count = value;
   endfunction

   function int unsigned live_count();
      return (entry_count < ptnc_pkg::PALETTE_DEPTH) ? entry_count : ptnc_pkg::PALETTE_DEPTH;
   endfunction

   function int unsigned outstanding();
      return expected_rsp.size();
   endfunction

   function int unsigned sq_gap(logic [7:0] a, logic [7:0] b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
   endfunction

   function palette_rsp_type predict_response(palette_req_type r);
      palette_rsp_type     p;
      ptnc_pkg::entry_type e;
      int unsigned         live, best, d, u;
      logic                exact;
      p         = '0;
      p.run_end = r.last_in_run;
      live      = live_count();
      case (r.action)
         ptnc_pkg::ACT_WRITE: begin
            if (r.index < live)
               mirror[r.index] = {r.entry_flags, r.blue, r.green, r.red};
            else
               p.status = ptnc_pkg::STAT_RANGE;
         end
         ptnc_pkg::ACT_READ: begin
            if (r.index < live) begin
               e = mirror[r.index];
               {p.flags, p.blue, p.green, p.red} = {e.flags, e.blue, e.green, e.red};
            end else begin
               p.status = ptnc_pkg::STAT_RANGE;
            end
         end
         ptnc_pkg::ACT_NEAREST: begin
            if (live == 0) begin
               p.status = ptnc_pkg::STAT_EMPTY;
            end else begin
               best  = ptnc_pkg::DIST_START;
               exact = 1'b0;
               for (u = 0; u < live && !exact; u++) begin
                  e = mirror[u];
                  d = sq_gap(e.red, r.red) + sq_gap(e.green, r.green)
                      + sq_gap(e.blue, r.blue);
                  if (d < best) begin
                     best            = d;
                     p.nearest_index = 8'(u);
                  end
                  exact = (d == 0);
               end
            end
         end
         default: begin
            if (r.direct_rgb) begin
               {p.red, p.green, p.blue} = {r.red, r.green, r.blue};
            end else begin
               e = (r.index < live) ? mirror[r.index] : mirror[0];
               {p.red, p.green, p.blue} = {e.red, e.green, e.blue};
            end
         end
      endcase
      return p;
   endfunction

   function void note_request(palette_req_type r);
      expected_rsp.push_back(predict_response(r));
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   function void check_response(palette_rsp_type got);
      palette_rsp_type want;
      if (expected_rsp.size() == 0) begin
         $error("response with no item outstanding");
         errors++;
         return;
      end
      want = expected_rsp.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("out_red", 16'(want.red), 16'(got.red));
      compare_field("out_green", 16'(want.green), 16'(got.green));
      compare_field("out_blue", 16'(want.blue), 16'(got.blue));
      compare_field("out_flags", 16'(want.flags), 16'(got.flags));
      compare_field("nearest_index", 16'(want.nearest_index), 16'(got.nearest_index));
      compare_field("run_end", 16'(want.run_end), 16'(got.run_end));
   endfunction
endclass

module palette_table_nearest_color_tb;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action      = ptnc_pkg::ACT_WRITE;
   logic [15:0] req_index       = '0;
   logic [7:0]  req_red         = '0;
   logic [7:0]  req_green       = '0;
   logic [7:0]  req_blue        = '0;
   logic [7:0]  req_entry_flags = '0;
   logic        req_direct_rgb  = 1'b0;
   logic        req_last_in_run = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic [7:0]  rsp_out_flags;
   logic [7:0]  rsp_nearest_index;
   logic        rsp_run_end;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_entry_count = '0;

   palette_mirror board;
   bit            calm = 1'b0;

   palette_table_nearest_color u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_index         (req_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_entry_flags   (req_entry_flags),
      .req_direct_rgb    (req_direct_rgb),
      .req_last_in_run   (req_last_in_run),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_blue      (rsp_out_blue),
      .rsp_out_flags     (rsp_out_flags),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_run_end       (rsp_run_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_entry_count   (csr_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response({rsp_status, rsp_out_red, rsp_out_green, rsp_out_blue,
                               rsp_out_flags, rsp_nearest_index, rsp_run_end});
      rsp_ready <= calm || ($urandom_range(99) >= 22);
   end

   function automatic palette_req_type palette_op(logic [1:0] action, logic [15:0] index,
                                                  logic [7:0] red, logic [7:0] green,
                                                  logic [7:0] blue, logic [7:0] flags,
                                                  logic direct, logic last);
      return {action, index, red, green, blue, flags, direct, last};
   endfunction

   function automatic palette_req_type random_request();
      palette_req_type     r;
      ptnc_pkg::entry_type e;
      int unsigned         live, pick;
      live = board.live_count();
      pick = $urandom_range(99);
      if (pick < 30)      r.action = ptnc_pkg::ACT_WRITE;
      else if (pick < 50) r.action = ptnc_pkg::ACT_READ;
      else if (pick < 75) r.action = ptnc_pkg::ACT_NEAREST;
      else                r.action = ptnc_pkg::ACT_RESOLVE;
      pick = $urandom_range(99);
      if (live != 0 && pick < 75) r.index = 16'($urandom_range(live - 1));
      else if (pick < 88)         r.index = 16'(live + $urandom_range(3));
      else                        r.index = 16'($urandom);
      e    = (live != 0) ? board.mirror[$urandom_range(live - 1)] : '0;
      pick = $urandom_range(99);
      if (live != 0 && pick < 35) begin
         {r.red, r.green, r.blue} = {e.red, e.green, e.blue};
      end else if (live != 0 && pick < 55) begin
         r.red   = e.red + 8'($urandom_range(6)) - 8'd3;
         r.green = e.green + 8'($urandom_range(6)) - 8'd3;
         r.blue  = e.blue + 8'($urandom_range(6)) - 8'd3;
      end else if (pick < 62) begin
         r.red   = $urandom_range(1) ? 8'hFF : 8'h00;
         r.green = $urandom_range(1) ? 8'hFF : 8'h00;
         r.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
      end else begin
         r.red   = 8'($urandom);
         r.green = 8'($urandom);
         r.blue  = 8'($urandom);
      end
      r.entry_flags = 8'($urandom);
      r.direct_rgb  = 1'($urandom);
      r.last_in_run = ($urandom_range(3) == 0);
      return r;
   endfunction

   // valid stays high from one item to the next unless an idle gap is taken
   task automatic send_request(input palette_req_type r);
      if (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (!calm && $urandom_range(99) < 22) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_action, req_index, req_red, req_green, req_blue, req_entry_flags,
       req_direct_rgb, req_last_in_run} <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_entry_count(input logic [ptnc_pkg::REG_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_entry_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.set_entry_count(value);
   endtask

   task automatic run_phase(input logic [ptnc_pkg::REG_W-1:0] count,
                            input int unsigned items);
      palette_req_type r;
      int unsigned     sent, len, k;
      drain_results();
      write_entry_count(count);
      sent = 0;
      while (sent < items) begin
         r = random_request();
         if ((r.action == ptnc_pkg::ACT_WRITE || r.action == ptnc_pkg::ACT_READ)
             && $urandom_range(3) == 0) begin
            // run of consecutive entries, last item marked
            len = $urandom_range(8, 2);
            for (k = 0; k < len; k++) begin
               r.last_in_run = (k == len - 1);
               send_request(r);
               r.index       = r.index + 16'd1;
               r.red         = 8'($urandom);
               r.green       = 8'($urandom);
               r.blue        = 8'($urandom);
               r.entry_flags = 8'($urandom);
            end
            sent += len;
         end else begin
            send_request(r);
            sent++;
         end
         if ($urandom_range(39) == 0)
            drain_results();
      end
   endtask

   initial begin
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty palette
      send_request(palette_op(ptnc_pkg::ACT_NEAREST, 16'd0, 8'd1, 8'd2, 8'd3, 8'h00,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_RESOLVE, 16'd0, 8'd9, 8'd9, 8'd9, 8'h00,
                              1'b0, 1'b1));
      send_request(palette_op(ptnc_pkg::ACT_RESOLVE, 16'hFFFF, 8'hFF, 8'h00, 8'hFF, 8'hFF,
                              1'b1, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_WRITE, 16'd0, 8'd5, 8'd6, 8'd7, 8'h81,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_READ, 16'd0, 8'd0, 8'd0, 8'd0, 8'h00,
                              1'b0, 1'b1));
      drain_results();

      // count above the depth, effective count is the full table
      write_entry_count(9'd511);
      send_request(palette_op(ptnc_pkg::ACT_WRITE, 16'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_WRITE, 16'd1, 8'd10, 8'd20, 8'd30, 8'h5A,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_WRITE, 16'd2, 8'd10, 8'd20, 8'd30, 8'hA5,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_WRITE, 16'd255, 8'd1, 8'd1, 8'd1, 8'h00,
                              1'b1, 1'b1));
      send_request(palette_op(ptnc_pkg::ACT_WRITE, 16'd256, 8'd3, 8'd3, 8'd3, 8'h03,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_WRITE, 16'hFFFF, 8'd4, 8'd4, 8'd4, 8'h04,
                              1'b0, 1'b1));
      send_request(palette_op(ptnc_pkg::ACT_READ, 16'd255, 8'd0, 8'd0, 8'd0, 8'h00,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_READ, 16'd0, 8'd0, 8'd0, 8'd0, 8'h00,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_READ, 16'd256, 8'd0, 8'd0, 8'd0, 8'h00,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_READ, 16'hFFFF, 8'd0, 8'd0, 8'd0, 8'h00,
                              1'b0, 1'b1));
      send_request(palette_op(ptnc_pkg::ACT_NEAREST, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_NEAREST, 16'd0, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_NEAREST, 16'd0, 8'd10, 8'd20, 8'd31, 8'h00,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_NEAREST, 16'd0, 8'd128, 8'd128, 8'd128, 8'h00,
                              1'b1, 1'b1));
      send_request(palette_op(ptnc_pkg::ACT_RESOLVE, 16'd1, 8'd0, 8'd0, 8'd0, 8'hFF,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_RESOLVE, 16'd300, 8'd0, 8'd0, 8'd0, 8'h00,
                              1'b0, 1'b0));
      send_request(palette_op(ptnc_pkg::ACT_RESOLVE, 16'hFFFF, 8'h00, 8'hFF, 8'h00, 8'h00,
                              1'b1, 1'b1));

      run_phase(9'd256, 45);
      run_phase(9'd1, 40);
      calm = 1'b1;
      run_phase(9'd2, 45);
      calm = 1'b0;
      run_phase(9'd511, 45);
      run_phase(9'd255, 45);
      run_phase(9'd17, 45);
      run_phase(9'(  $urandom_range(40, 3)), 45);
      run_phase(9'd0, 25);
      run_phase(9'd128, 45);
      run_phase(9'd300, 45);
      run_phase(9'(  $urandom_range(255, 3)), 30);

      drain_results();
      repeat (300) @(posedge clock);
      if (board.errors == 0 && board.outstanding() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
